// File: design/pfba_pkg.sv
// shared types and constants of the page frame bitmap allocator
`default_nettype none

package pfba_pkg;

  localparam int unsigned CNT_W     = 11;
  localparam int unsigned FRAME_W   = 10;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC_FALLBACK = 2'd0,
    OP_ALLOC_POOL     = 2'd1,
    OP_FREE           = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic               pool;
    logic [COUNT_W-1:0] request_count;
    logic [FRAME_W-1:0] frame_index;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic               granted_pool;
    status_e            status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// File: design/pfba_word_scan.sv
// lowest free bit search within one bitmap word
`default_nettype none

module pfba_word_scan #(
  parameter int unsigned WORD_W = 32
) (
  input  wire logic [WORD_W-1:0]         word_i,
  input  wire logic [WORD_W-1:0]         mask_i,
  output logic                           found_o,
  output logic [$clog2(WORD_W)-1:0]      idx_o,
  output logic [WORD_W-1:0]              word_o
);

  localparam int unsigned WB = $clog2(WORD_W);

  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] lowbit;

  assign hit     = word_i & mask_i;
  // two's complement trick isolates the lowest set bit
  assign lowbit  = hit & (~hit + WORD_W'(1));
  assign found_o = |hit;
  assign word_o  = word_i & ~lowbit;

  always_comb begin
    idx_o = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (lowbit[j]) begin
        idx_o = idx_o | WB'(j);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/page_frame_bitmap_allocator.sv
// free request: the bitmap word is read on entry to S_FREE and the result is registered from it
// no-space result: registered at the accepting edge. allocate: the first word is read, then
// each scan step passes one bitmap word without a grant or grants one frame
// a single-port-read bitmap memory sets the rate: one word or one grant per cycle
// after reset a clearing pass writes each memory row once to set every frame free; busy
// stays high meanwhile. results cannot be stalled by the receiver
`default_nettype none

module page_frame_bitmap_allocator #(
  parameter int unsigned FRAMES  = 1024,
  parameter int unsigned MAX_RUN = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pfba_pkg::req_t                req_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pfba_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                               result_valid_o,
  output pfba_pkg::res_t                     result_o
);

  import pfba_pkg::*;

  localparam int unsigned WORD_W = (FRAMES < 32) ? FRAMES : 32;
  localparam int unsigned WB     = $clog2(WORD_W);
  localparam int unsigned WORDS  = (FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned AW     = WA + 1;
  localparam int unsigned ROWS   = 2 ** AW;
  localparam int unsigned XW     = $clog2(WORDS * WORD_W + 1);
  localparam int unsigned CMP_W  = (XW > CNT_W) ? XW : CNT_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   cfg_main_q, cfg_swap_q;
  logic [CNT_W-1:0]   used_main_q, used_main_d;
  logic [CNT_W-1:0]   used_swap_q, used_swap_d;
  logic               pool_q, pool_d;
  logic [COUNT_W-1:0] remain_q, remain_d;
  logic [WA-1:0]      word_q, word_d;
  logic               first_q, first_d;
  logic [WORD_W-1:0]  work_q, work_d;
  logic [FRAME_W-1:0] fidx_q, fidx_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               result_valid_q, result_valid_d;
  res_t               result_q, result_d;

  logic [WORD_W-1:0]  mem [ROWS];
  logic [WORD_W-1:0]  rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;

  function automatic logic [CNT_W-1:0] size_of(logic [CNT_W-1:0] c);
    return (32'(c) < FRAMES) ? c : CNT_W'(FRAMES);
  endfunction

  function automatic logic [CNT_W-1:0] free_of(logic [CNT_W-1:0] sz, logic [CNT_W-1:0] used);
    return (sz > used) ? (sz - used) : '0;
  endfunction

  // pool selection at the accepting edge
  logic [CNT_W-1:0]   main_size, swap_size, sel_size;
  logic [CNT_W-1:0]   free_main, free_swap;
  logic [COUNT_W-1:0] n_sat;
  logic               acc_pool;
  logic               acc_ok;

  assign main_size = size_of(cfg_main_q);
  assign swap_size = size_of(cfg_swap_q);
  assign free_main = free_of(main_size, used_main_q);
  assign free_swap = free_of(swap_size, used_swap_q);
  assign sel_size  = pool_q ? swap_size : main_size;

  always_comb begin
    n_sat = (req_i.request_count > COUNT_W'(MAX_RUN)) ? COUNT_W'(MAX_RUN)
                                                      : req_i.request_count;
    if (req_i.op == OP_ALLOC_FALLBACK) begin
      acc_pool = (free_main >= CNT_W'(n_sat)) ? 1'b0 : 1'b1;
    end else begin
      acc_pool = req_i.pool;
    end
    acc_ok = (acc_pool ? free_swap : free_main) >= CNT_W'(n_sat);
  end

  // word under scan, limited to the frames present in the pool
  logic [CMP_W-1:0]  base, base_next, sz_ext, lim;
  logic [WORD_W-1:0] cur, mask;
  logic              scan_found;
  logic [WB-1:0]     scan_idx;
  logic [WORD_W-1:0] scan_word;
  logic              scan_end;
  logic              free_bit, free_bad;

  assign base      = CMP_W'({word_q, {WB{1'b0}}});
  assign base_next = base + CMP_W'(WORD_W);
  assign sz_ext    = CMP_W'(sel_size);
  assign lim       = sz_ext - base;
  assign cur       = first_q ? rdata_q : work_q;
  assign scan_end  = (word_q == WA'(WORDS - 1)) || (base_next >= sz_ext);

  always_comb begin
    if (sz_ext <= base) begin
      mask = '0;
    end else if (lim >= CMP_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_W{1'b1}} << lim[WB-1:0]);
    end
  end

  pfba_word_scan #(
    .WORD_W (WORD_W)
  ) u_scan (
    .word_i  (cur),
    .mask_i  (mask),
    .found_o (scan_found),
    .idx_o   (scan_idx),
    .word_o  (scan_word)
  );

  assign free_bit = rdata_q[fidx_q[WB-1:0]];
  assign free_bad = (CNT_W'(fidx_q) >= sel_size) || (32'(fidx_q) >= FRAMES) || free_bit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_i.op) inside
            OP_ALLOC_FALLBACK, OP_ALLOC_POOL: begin
              if (n_sat != '0 && acc_ok) begin
                state_d = S_SCAN;
              end
            end
            OP_FREE: state_d = S_FREE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_found ? (remain_q == COUNT_W'(1)) : scan_end) begin
          state_d = S_IDLE;
        end
      end
      S_FREE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    used_main_d    = used_main_q;
    used_swap_d    = used_swap_q;
    pool_d         = pool_q;
    remain_d       = remain_q;
    word_d         = word_q;
    first_d        = first_q;
    work_d         = work_q;
    fidx_d         = fidx_q;
    clr_d          = clr_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    mem_we         = 1'b0;
    mem_waddr      = {pool_q, word_q};
    mem_wdata      = cur;
    mem_raddr      = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '1;
        clr_d     = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_i.op) inside
            OP_ALLOC_FALLBACK, OP_ALLOC_POOL: begin
              if (n_sat != '0) begin
                if (acc_ok) begin
                  pool_d    = acc_pool;
                  remain_d  = n_sat;
                  word_d    = '0;
                  first_d   = 1'b1;
                  mem_raddr = {acc_pool, WA'(0)};
                end else begin
                  result_valid_d         = 1'b1;
                  result_d.granted_frame = '0;
                  result_d.granted_pool  = acc_pool;
                  result_d.status        = STATUS_NO_SPACE;
                  result_d.last          = 1'b1;
                end
              end
            end
            OP_FREE: begin
              pool_d    = req_i.pool;
              fidx_d    = req_i.frame_index;
              mem_raddr = {req_i.pool, WA'(req_i.frame_index >> WB)};
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          result_valid_d         = 1'b1;
          result_d.granted_frame = FRAME_W'(base + CMP_W'(scan_idx));
          result_d.granted_pool  = pool_q;
          result_d.status        = STATUS_OK;
          result_d.last          = (remain_q == COUNT_W'(1));
          if (pool_q) begin
            used_swap_d = used_swap_q + CNT_W'(1);
          end else begin
            used_main_d = used_main_q + CNT_W'(1);
          end
          remain_d = remain_q - COUNT_W'(1);
          work_d   = scan_word;
          first_d  = 1'b0;
          if (remain_q == COUNT_W'(1)) begin
            mem_we    = 1'b1;
            mem_wdata = scan_word;
          end
        end else begin
          // word exhausted: write back what was taken and move on unless it was the last word
          mem_we    = 1'b1;
          mem_wdata = cur;
          if (!scan_end) begin
            word_d    = word_q + WA'(1);
            first_d   = 1'b1;
            mem_raddr = {pool_q, word_q + WA'(1)};
          end
        end
      end
      S_FREE: begin
        result_valid_d         = 1'b1;
        result_d.granted_frame = fidx_q;
        result_d.granted_pool  = pool_q;
        result_d.status        = free_bad ? STATUS_BAD_FREE : STATUS_OK;
        result_d.last          = 1'b1;
        if (!free_bad) begin
          mem_we    = 1'b1;
          mem_waddr = {pool_q, WA'(fidx_q >> WB)};
          mem_wdata = rdata_q | (WORD_W'(1) << fidx_q[WB-1:0]);
          if (pool_q) begin
            if (used_swap_q != '0) begin
              used_swap_d = used_swap_q - CNT_W'(1);
            end
          end else begin
            if (used_main_q != '0) begin
              used_main_d = used_main_q - CNT_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      used_main_q    <= '0;
      used_swap_q    <= '0;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
      cfg_main_q     <= CFG_RESET;
      cfg_swap_q     <= CFG_RESET;
    end else begin
      state_q        <= state_d;
      used_main_q    <= used_main_d;
      used_swap_q    <= used_swap_d;
      clr_q          <= clr_d;
      result_valid_q <= result_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MAIN_FRAMES: cfg_main_q <= cfg_data_i;
          CFG_SWAP_FRAMES: cfg_swap_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pool_q   <= pool_d;
    remain_q <= remain_d;
    word_q   <= word_d;
    first_q  <= first_d;
    work_q   <= work_d;
    fidx_q   <= fidx_d;
    result_q <= result_d;
  end

  // bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire
